[sv/mecanum_wheel_mixer_with_speed_limit_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the mecanum wheel mixer
// Clocked, reset-qualified assertion shorthands shared by the RTL files.
// ----------------------------------------------------------------------------
`ifndef MECANUM_WHEEL_MIXER_WITH_SPEED_LIMIT_ASSERT_SVH
`define MECANUM_WHEEL_MIXER_WITH_SPEED_LIMIT_ASSERT_SVH

// same-cycle property, sampled on the rising clock edge outside reset
`define MWM_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// antecedent in one cycle implies consequent in the next
`define MWM_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

[sv/mwm_pkg.sv]
// ----------------------------------------------------------------------------
// mwm_pkg
// Widths, register indexes and shared types of the mecanum wheel mixer.
// ----------------------------------------------------------------------------
package mwm_pkg;

   localparam int IN_W        = 16;
   localparam int OUT_W       = 16;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 16;
   localparam int LIM_W       = 15;
   localparam int LANES       = 4;
   // 32-bit x/y (Q.20), 33-bit yaw term, three-term sum
   localparam int SUM_W       = 35;
   localparam int PROD_W      = SUM_W + 17;
   localparam int RPM_SHIFT   = 28;
   // wheel magnitude in rpm stays below 2^21
   localparam int MAG_W       = 21;
   localparam int DVD_W       = MAG_W + LIM_W;
   localparam int CMP_W       = 2 * MAG_W;
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = 2;
   localparam int QUEUE_CNT_W = 3;

   // wheels one and three are negated
   localparam logic [LANES-1:0] LANE_NEGATED = 4'b0101;

   localparam logic [CSR_IDX_W-1:0] CSR_ARM_SUM         = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MOTOR_GAIN      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SPEED_CAP       = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_FIXED_DIV_MODE  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_FIXED_DIVISOR   = 3'd4;

   typedef struct packed {
      logic [15:0]      arm_sum;
      logic [15:0]      motor_gain;
      logic [LIM_W-1:0] speed_cap;
      logic             fixed_divisor_mode;
      logic [LIM_W-1:0] fixed_divisor;
   } cfg_type;

   // one classified command, handed from front to back
   typedef struct packed {
      logic [LANES-1:0][MAG_W-1:0] mag;
      logic [LANES-1:0]            neg;
      logic [MAG_W-1:0]            divisor;
      logic                        limited;
   } item_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

[sv/mwm_front.sv]
// ----------------------------------------------------------------------------
// mwm_front
// Accepts velocity requests, forms wheel sums and rpm magnitudes, and decides
// whether proportional limiting applies. Five stages, frozen while queue full.
// ----------------------------------------------------------------------------
module mwm_front (
   input  logic                              clock,
   input  logic                              reset,
   input  mwm_pkg::cfg_type                  cfg,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic signed [mwm_pkg::IN_W-1:0]   vel_x,
   input  logic signed [mwm_pkg::IN_W-1:0]   vel_y,
   input  logic signed [mwm_pkg::IN_W-1:0]   yaw_rate,
   input  mwm_pkg::queue_status_type         q_status,
   output logic                              push,
   output mwm_pkg::item_type                 item
);

   logic adv;

   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;
   logic signed [mwm_pkg::IN_W-1:0]   x1_ff, y1_ff;
   logic signed [mwm_pkg::IN_W+16:0]  w1_ff, w1_in;
   logic signed [mwm_pkg::SUM_W-1:0]  sum_ff [0:mwm_pkg::LANES-1];
   logic signed [mwm_pkg::SUM_W-1:0]  sum_in [0:mwm_pkg::LANES-1];
   logic signed [mwm_pkg::PROD_W-1:0] prod_ff [0:mwm_pkg::LANES-1];
   logic signed [mwm_pkg::PROD_W-1:0] prod_in [0:mwm_pkg::LANES-1];
   logic [mwm_pkg::MAG_W-1:0]         mag_ff [0:mwm_pkg::LANES-1];
   logic [mwm_pkg::MAG_W-1:0]         mag_in [0:mwm_pkg::LANES-1];
   logic [mwm_pkg::LANES-1:0]         neg_ff, neg_in;
   mwm_pkg::item_type                 item_ff, item_in;

   assign adv       = !q_status.full;
   assign req_ready = adv;
   assign push      = v5_ff && adv;
   assign item      = item_ff;

   // yaw term: Q4.12 times Q8.8 gives Q.20
   assign w1_in = yaw_rate * $signed({1'b0, cfg.arm_sum});

   // four mecanum sums
   always_comb begin
      logic signed [mwm_pkg::SUM_W-1:0] xs, ys, ws;
      xs = {{3{x1_ff[mwm_pkg::IN_W-1]}}, x1_ff, 16'b0};
      ys = {{3{y1_ff[mwm_pkg::IN_W-1]}}, y1_ff, 16'b0};
      ws = {{2{w1_ff[mwm_pkg::IN_W+16]}}, w1_ff};
      sum_in[0] = -xs - ys + ws;
      sum_in[1] = -xs + ys - ws;
      sum_in[2] = -xs + ys + ws;
      sum_in[3] = -xs - ys - ws;
   end

   // gain multiply, then magnitude truncated toward zero
   always_comb begin
      logic [mwm_pkg::PROD_W-1:0] a;
      for (int l = 0; l < mwm_pkg::LANES; l++) begin
         prod_in[l] = sum_ff[l] * $signed({1'b0, cfg.motor_gain});
         a = prod_ff[l][mwm_pkg::PROD_W-1] ? -prod_ff[l] : prod_ff[l];
         mag_in[l] = a[mwm_pkg::RPM_SHIFT+mwm_pkg::MAG_W-1:mwm_pkg::RPM_SHIFT];
         neg_in[l] = prod_ff[l][mwm_pkg::PROD_W-1] ^ mwm_pkg::LANE_NEGATED[l];
      end
   end

   // largest magnitude, divisor choice (fixed or largest) and limit decision
   always_comb begin
      logic [mwm_pkg::MAG_W-1:0] m01, m23, mx;
      m01 = (mag_ff[0] > mag_ff[1]) ? mag_ff[0] : mag_ff[1];
      m23 = (mag_ff[2] > mag_ff[3]) ? mag_ff[2] : mag_ff[3];
      mx  = (m01 > m23) ? m01 : m23;
      for (int l = 0; l < mwm_pkg::LANES; l++) begin
         item_in.mag[l] = mag_ff[l];
      end
      item_in.neg     = neg_ff;
      item_in.divisor = cfg.fixed_divisor_mode ?
                        mwm_pkg::MAG_W'(cfg.fixed_divisor) : mx;
      item_in.limited = item_in.divisor > mwm_pkg::MAG_W'(cfg.speed_cap);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= req_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
      end
      if (adv) begin
         x1_ff   <= vel_x;
         y1_ff   <= vel_y;
         w1_ff   <= w1_in;
         sum_ff  <= sum_in;
         prod_ff <= prod_in;
         mag_ff  <= mag_in;
         neg_ff  <= neg_in;
         item_ff <= item_in;
      end
   end

endmodule

[sv/mwm_queue.sv]
// ----------------------------------------------------------------------------
// mwm_queue
// Four-entry request queue decoupling the front stages from the back stages.
// ----------------------------------------------------------------------------
`include "mecanum_wheel_mixer_with_speed_limit_assert.svh"

module mwm_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  mwm_pkg::item_type         push_item,
   input  logic                      pop,
   output mwm_pkg::item_type         pop_item,
   output mwm_pkg::queue_status_type status
);

   mwm_pkg::item_type                  entry_ff [0:mwm_pkg::QUEUE_DEPTH-1];
   logic [mwm_pkg::QUEUE_PTR_W-1:0]    wr_ptr_ff, rd_ptr_ff;
   logic [mwm_pkg::QUEUE_CNT_W-1:0]    count_ff, count_in;

   assign status.full  = count_ff == mwm_pkg::QUEUE_CNT_W'(mwm_pkg::QUEUE_DEPTH);
   assign status.empty = count_ff == '0;
   assign pop_item     = entry_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) count_in = count_ff + 1'b1;
      if (pop && !push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (pop)  rd_ptr_ff <= rd_ptr_ff + 1'b1;
         count_ff <= count_in;
      end
      if (push) entry_ff[wr_ptr_ff] <= push_item;
   end

   `MWM_ASSERT(a_no_push_full, !(push && status.full), "push into full queue")
   `MWM_ASSERT(a_no_pop_empty, !(pop && status.empty), "pop from empty queue")
   `MWM_ASSERT(a_count_bound, count_ff <= mwm_pkg::QUEUE_CNT_W'(mwm_pkg::QUEUE_DEPTH),
      "queue count beyond depth")

endmodule

[sv/mwm_back.sv]
// ----------------------------------------------------------------------------
// mwm_back
// Scales wheel magnitudes by limit/divisor with a pipelined restoring divider
// (one quotient bit a stage), then restores sign and saturates to 16 bits.
// ----------------------------------------------------------------------------
`include "mecanum_wheel_mixer_with_speed_limit_assert.svh"

module mwm_back (
   input  logic                              clock,
   input  logic                              reset,
   input  mwm_pkg::cfg_type                  cfg,
   input  mwm_pkg::queue_status_type         q_status,
   input  mwm_pkg::item_type                 item,
   output logic                              pop,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic signed [mwm_pkg::OUT_W-1:0]  motor_one_speed,
   output logic signed [mwm_pkg::OUT_W-1:0]  motor_two_speed,
   output logic signed [mwm_pkg::OUT_W-1:0]  motor_three_speed,
   output logic signed [mwm_pkg::OUT_W-1:0]  motor_four_speed,
   output logic                              was_limited
);

   localparam int NS = mwm_pkg::MAG_W;

   logic adv;

   logic [NS:0]                     v_ff;
   logic [mwm_pkg::DVD_W-1:0]       rem_ff [0:NS][0:mwm_pkg::LANES-1];
   logic [mwm_pkg::DVD_W-1:0]       rem_in [0:NS][0:mwm_pkg::LANES-1];
   logic [mwm_pkg::MAG_W-1:0]       quo_ff [0:NS][0:mwm_pkg::LANES-1];
   logic [mwm_pkg::MAG_W-1:0]       quo_in [0:NS][0:mwm_pkg::LANES-1];
   logic [mwm_pkg::MAG_W-1:0]       div_ff [0:NS];
   logic [mwm_pkg::LANES-1:0]       neg_ff [0:NS];
   logic [NS:0]                     lim_ff;
   logic [mwm_pkg::MAG_W-1:0]       div0_in;

   logic                             rsp_valid_ff;
   logic signed [mwm_pkg::OUT_W-1:0] speed_ff [0:mwm_pkg::LANES-1];
   logic signed [mwm_pkg::OUT_W-1:0] speed_in [0:mwm_pkg::LANES-1];
   logic                             limited_ff;

   assign adv = !rsp_valid_ff || rsp_ready;
   assign pop = adv && !q_status.empty;

   // unlimited items divide by one so the magnitude passes through
   assign div0_in = item.limited ? item.divisor : mwm_pkg::MAG_W'(1);

   // dividend load and one quotient bit per stage
   always_comb begin
      logic [mwm_pkg::CMP_W-1:0] sh, r;
      for (int l = 0; l < mwm_pkg::LANES; l++) begin
         rem_in[0][l] = item.limited ? item.mag[l] * cfg.speed_cap
                                     : mwm_pkg::DVD_W'(item.mag[l]);
         quo_in[0][l] = '0;
      end
      for (int s = 1; s <= NS; s++) begin
         for (int l = 0; l < mwm_pkg::LANES; l++) begin
            sh = mwm_pkg::CMP_W'(div_ff[s-1]) << (NS - s);
            r  = mwm_pkg::CMP_W'(rem_ff[s-1][l]);
            rem_in[s][l] = rem_ff[s-1][l];
            quo_in[s][l] = quo_ff[s-1][l];
            if (r >= sh) begin
               rem_in[s][l] = mwm_pkg::DVD_W'(r - sh);
               quo_in[s][l][NS-s] = 1'b1;
            end
         end
      end
   end

   // sign restore and 16-bit saturation
   always_comb begin
      logic [mwm_pkg::MAG_W-1:0] q;
      for (int l = 0; l < mwm_pkg::LANES; l++) begin
         q = quo_ff[NS][l];
         if (neg_ff[NS][l]) begin
            if (q > mwm_pkg::MAG_W'(32768)) speed_in[l] = 16'sh8000;
            else speed_in[l] = -$signed(q[mwm_pkg::OUT_W-1:0]);
         end else begin
            if (q > mwm_pkg::MAG_W'(32767)) speed_in[l] = 16'sh7fff;
            else speed_in[l] = $signed(q[mwm_pkg::OUT_W-1:0]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         v_ff         <= {v_ff[NS-1:0], pop};
         rsp_valid_ff <= v_ff[NS];
      end
      if (adv) begin
         rem_ff    <= rem_in;
         quo_ff    <= quo_in;
         div_ff[0] <= div0_in;
         neg_ff[0] <= item.neg;
         lim_ff[0] <= item.limited;
         for (int s = 1; s <= NS; s++) begin
            div_ff[s] <= div_ff[s-1];
            neg_ff[s] <= neg_ff[s-1];
            lim_ff[s] <= lim_ff[s-1];
         end
         speed_ff   <= speed_in;
         limited_ff <= lim_ff[NS];
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign motor_one_speed   = speed_ff[0];
   assign motor_two_speed   = speed_ff[1];
   assign motor_three_speed = speed_ff[2];
   assign motor_four_speed  = speed_ff[3];
   assign was_limited       = limited_ff;

   `MWM_ASSERT(a_rem_below_div, !v_ff[NS] ||
      ((rem_ff[NS][0] < mwm_pkg::DVD_W'(div_ff[NS])) &&
       (rem_ff[NS][3] < mwm_pkg::DVD_W'(div_ff[NS]))), "divider remainder not reduced")
   `MWM_ASSERT_NEXT(a_stall_hold, rsp_valid_ff && !rsp_ready,
      rsp_valid_ff && $stable(speed_ff[0]) && $stable(limited_ff), "response lost on stall")

endmodule

[sv/mecanum_wheel_mixer_with_speed_limit.sv]
// ----------------------------------------------------------------------------
// mecanum_wheel_mixer_with_speed_limit
// Four-wheel mecanum inverse kinematics with proportional speed limiting.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one chassis command (vel_x, vel_y in Q12.4 cm/s, yaw_rate
//   in Q4.12 rad/s) with valid/ready. rsp_* returns the four motor speeds in
//   rpm and a was_limited flag, one response per request, in order.
//   csr_* writes one of five registers by index; csr_ready is always high.
//   Write registers only while no request is in flight.
// Timing:
//   One request per cycle sustained while responses are taken. A request passes
//   from the accepting edge through four front stages after the input
//   register, the queue entry register, the product load stage, 21 divider
//   stages (one quotient bit each), and the response register.
//   The divider pipeline depth sets the latency; throughput is one per cycle without stalls.
// Reset:
//   Synchronous, active high; clears all valid flags and the queue and loads
//   register defaults (arm 10240, gain 6144, limit 8000, mode 0, divisor 7000).
// Stall:
//   A held response freezes the back stages; the four-entry queue absorbs
//   front results, and req_ready drops once the queue is full.
// ----------------------------------------------------------------------------
module mecanum_wheel_mixer_with_speed_limit (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic signed [mwm_pkg::IN_W-1:0]       req_vel_x,
   input  logic signed [mwm_pkg::IN_W-1:0]       req_vel_y,
   input  logic signed [mwm_pkg::IN_W-1:0]       req_yaw_rate,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [mwm_pkg::OUT_W-1:0]      rsp_motor_one_speed,
   output logic signed [mwm_pkg::OUT_W-1:0]      rsp_motor_two_speed,
   output logic signed [mwm_pkg::OUT_W-1:0]      rsp_motor_three_speed,
   output logic signed [mwm_pkg::OUT_W-1:0]      rsp_motor_four_speed,
   output logic                                  rsp_was_limited,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [mwm_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [mwm_pkg::CSR_DATA_W-1:0]        csr_wdata
);

   mwm_pkg::cfg_type          cfg_ff;
   mwm_pkg::queue_status_type q_status;
   mwm_pkg::item_type         push_item, pop_item;
   logic                      push, pop;

   assign csr_ready = 1'b1;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.arm_sum            <= 16'd10240;
         cfg_ff.motor_gain         <= 16'd6144;
         cfg_ff.speed_cap          <= 15'd8000;
         cfg_ff.fixed_divisor_mode <= 1'b0;
         cfg_ff.fixed_divisor      <= 15'd7000;
      end else if (csr_valid) begin
         unique case (csr_index)
            mwm_pkg::CSR_ARM_SUM:         cfg_ff.arm_sum    <= csr_wdata;
            mwm_pkg::CSR_MOTOR_GAIN:      cfg_ff.motor_gain <= csr_wdata;
            mwm_pkg::CSR_SPEED_CAP:
               cfg_ff.speed_cap <= csr_wdata[mwm_pkg::LIM_W-1:0];
            mwm_pkg::CSR_FIXED_DIV_MODE:  cfg_ff.fixed_divisor_mode <= csr_wdata[0];
            mwm_pkg::CSR_FIXED_DIVISOR:
               cfg_ff.fixed_divisor <= csr_wdata[mwm_pkg::LIM_W-1:0];
            default: ;
         endcase
      end
   end

   mwm_front u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .vel_x     (req_vel_x),
      .vel_y     (req_vel_y),
      .yaw_rate  (req_yaw_rate),
      .q_status  (q_status),
      .push      (push),
      .item      (push_item)
   );

   mwm_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .pop_item  (pop_item),
      .status    (q_status)
   );

   mwm_back u_back (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg_ff),
      .q_status          (q_status),
      .item              (pop_item),
      .pop               (pop),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .motor_one_speed   (rsp_motor_one_speed),
      .motor_two_speed   (rsp_motor_two_speed),
      .motor_three_speed (rsp_motor_three_speed),
      .motor_four_speed  (rsp_motor_four_speed),
      .was_limited       (rsp_was_limited)
   );

endmodule

[bench/mecanum_wheel_mixer_with_speed_limit_tb.sv]
// ----------------------------------------------------------------------------
// mecanum_wheel_mixer_with_speed_limit_tb
// Self-checking bench for the mecanum wheel mixer with speed limiting.
// Commands stream through a valid/ready driver under a series of register
// settings; a scoreboard predicts the four wheel speeds and the limit flag
// for every accepted request and checks each response in order.
// ----------------------------------------------------------------------------
module mecanum_wheel_mixer_with_speed_limit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [mwm_pkg::CSR_IDX_W-1:0] CSR_SPARE  = 3'd5;
   localparam logic [mwm_pkg::CSR_IDX_W-1:0] CSR_UNUSED = 3'd7;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 60;

   typedef struct {
      logic signed [mwm_pkg::IN_W-1:0] vel_x;
      logic signed [mwm_pkg::IN_W-1:0] vel_y;
      logic signed [mwm_pkg::IN_W-1:0] yaw_rate;
   } chassis_cmd_type;

   typedef struct {
      logic signed [mwm_pkg::OUT_W-1:0] speed [mwm_pkg::LANES];
      logic                             limited;
   } wheel_speeds_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic signed [mwm_pkg::IN_W-1:0] req_vel_x = '0, req_vel_y = '0, req_yaw_rate = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [mwm_pkg::OUT_W-1:0] rsp_motor_one_speed, rsp_motor_two_speed;
   logic signed [mwm_pkg::OUT_W-1:0] rsp_motor_three_speed, rsp_motor_four_speed;
   logic rsp_was_limited;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [mwm_pkg::CSR_IDX_W-1:0]  csr_index = '0;
   logic [mwm_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   // shadow registers
   longint arm_sum, motor_gain, speed_limit, fixed_mode, fixed_div;

   chassis_cmd_type  pending_cmds [$];
   wheel_speeds_type expected_speeds [$];
   bit     sender_hold = 1'b0;
   int     mismatches = 0, responses = 0, limited_seen = 0, phases = 0;
   longint cycle = 0;

   mecanum_wheel_mixer_with_speed_limit u_dut (.*);

   always #4 clock = ~clock;

   // quiet window with no idling on either side
   function automatic bit idle_now();
      if (cycle > 700 && cycle < 1400) return 1'b0;
      return $urandom_range(0, 99) < 18;
   endfunction

   // sum times gain, truncated toward zero to whole rpm
   function automatic longint to_rpm(longint sum);
      longint p, m;
      p = sum * motor_gain;
      m = (p < 0 ? -p : p) >>> mwm_pkg::RPM_SHIFT;
      return p < 0 ? -m : m;
   endfunction

   function automatic wheel_speeds_type mix_speeds(chassis_cmd_type c);
      wheel_speeds_type r;
      longint x, y, w, p, m, a, maxabs, dv;
      longint s [mwm_pkg::LANES];
      x = longint'(c.vel_x) * 65536;
      y = longint'(c.vel_y) * 65536;
      w = longint'(c.yaw_rate) * arm_sum;
      s[0] = -to_rpm(-x - y + w);
      s[1] =  to_rpm(-x + y - w);
      s[2] = -to_rpm(-x + y + w);
      s[3] =  to_rpm(-x - y - w);
      maxabs = 0;
      foreach (s[i]) begin
         a = s[i] < 0 ? -s[i] : s[i];
         if (a > maxabs) maxabs = a;
      end
      dv = fixed_mode ? fixed_div : maxabs;
      r.limited = dv > speed_limit;
      foreach (s[i]) begin
         if (r.limited) begin
            p = s[i] * speed_limit;
            m = (p < 0 ? -p : p) / dv;
            s[i] = p < 0 ? -m : m;
         end
         if (s[i] > 32767) s[i] = 32767;
         if (s[i] < -32768) s[i] = -32768;
         r.speed[i] = s[i][mwm_pkg::OUT_W-1:0];
      end
      return r;
   endfunction

   // request driver
   always @(posedge clock) begin
      bit accepted;
      accepted = req_valid && req_ready;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (accepted) begin
            expected_speeds.push_back(mix_speeds(pending_cmds[0]));
            void'(pending_cmds.pop_front());
         end
         if (!req_valid || accepted) begin
            if (pending_cmds.size() > 0 && !sender_hold && !idle_now()) begin
               req_valid    <= 1'b1;
               req_vel_x    <= pending_cmds[0].vel_x;
               req_vel_y    <= pending_cmds[0].vel_y;
               req_yaw_rate <= pending_cmds[0].yaw_rate;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // response monitor and scoreboard
   always @(posedge clock) begin
      wheel_speeds_type exp_r, got;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= !idle_now();
         if (rsp_valid && rsp_ready) begin
            got.speed[0] = rsp_motor_one_speed;
            got.speed[1] = rsp_motor_two_speed;
            got.speed[2] = rsp_motor_three_speed;
            got.speed[3] = rsp_motor_four_speed;
            got.limited  = rsp_was_limited;
            responses++;
            if (expected_speeds.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected response at cycle %0d", cycle);
            end else begin
               exp_r = expected_speeds.pop_front();
               if (exp_r.limited) limited_seen++;
               if (got.speed != exp_r.speed || got.limited !== exp_r.limited) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $display("mismatch cycle %0d: exp %0d %0d %0d %0d lim %0b",
                        cycle, exp_r.speed[0], exp_r.speed[1], exp_r.speed[2],
                        exp_r.speed[3], exp_r.limited);
                     $display("   got %0d %0d %0d %0d lim %0b",
                        got.speed[0], got.speed[1], got.speed[2], got.speed[3],
                        got.limited);
                  end
               end
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle <= cycle + 1;
      if (cycle >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle);
         $display("mecanum_wheel_mixer_with_speed_limit regression: fail");
         $finish;
      end
   end

   task automatic write_reg(logic [mwm_pkg::CSR_IDX_W-1:0] idx,
                            logic [mwm_pkg::CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         mwm_pkg::CSR_ARM_SUM:        arm_sum     = longint'(value);
         mwm_pkg::CSR_MOTOR_GAIN:     motor_gain  = longint'(value);
         mwm_pkg::CSR_SPEED_CAP:      speed_limit = longint'(value[mwm_pkg::LIM_W-1:0]);
         mwm_pkg::CSR_FIXED_DIV_MODE: fixed_mode  = longint'(value[0]);
         mwm_pkg::CSR_FIXED_DIVISOR:  fixed_div   = longint'(value[mwm_pkg::LIM_W-1:0]);
         default: ;
      endcase
   endtask

   task automatic set_all(longint a, longint g, longint lim, longint md, longint dv);
      write_reg(mwm_pkg::CSR_ARM_SUM, mwm_pkg::CSR_DATA_W'(a));
      write_reg(mwm_pkg::CSR_MOTOR_GAIN, mwm_pkg::CSR_DATA_W'(g));
      write_reg(mwm_pkg::CSR_SPEED_CAP, mwm_pkg::CSR_DATA_W'(lim));
      write_reg(mwm_pkg::CSR_FIXED_DIV_MODE, mwm_pkg::CSR_DATA_W'(md));
      write_reg(mwm_pkg::CSR_FIXED_DIVISOR, mwm_pkg::CSR_DATA_W'(dv));
   endtask

   function automatic logic signed [mwm_pkg::IN_W-1:0] rand_field();
      int sel;
      sel = $urandom_range(0, 9);
      if (sel == 0) return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
      if (sel < 4) return $signed(16'($urandom_range(0, 1023) - 512));
      return $signed(16'($urandom));
   endfunction

   task automatic add_cmd(int x, int y, int w);
      chassis_cmd_type c;
      c.vel_x    = $signed(mwm_pkg::IN_W'(x));
      c.vel_y    = $signed(mwm_pkg::IN_W'(y));
      c.yaw_rate = $signed(mwm_pkg::IN_W'(w));
      pending_cmds.push_back(c);
   endtask

   task automatic run_random(int n, bit pause_midway);
      repeat (n) add_cmd(int'(rand_field()), int'(rand_field()), int'(rand_field()));
      if (pause_midway) begin
         while (pending_cmds.size() > n / 2) @(posedge clock);
         sender_hold = 1'b1;
         while (expected_speeds.size() > 0) @(posedge clock);
         sender_hold = 1'b0;
      end
      while (pending_cmds.size() > 0 || expected_speeds.size() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      phases++;
   endtask

   initial begin
      arm_sum = 10240; motor_gain = 6144; speed_limit = 8000;
      fixed_mode = 0; fixed_div = 7000;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed: field extremes under reset registers
      add_cmd(0, 0, 0);
      add_cmd(32767, 0, 0);      add_cmd(-32768, 0, 0);
      add_cmd(0, 32767, 0);      add_cmd(0, -32768, 0);
      add_cmd(0, 0, 32767);      add_cmd(0, 0, -32768);
      add_cmd(32767, 32767, 32767);
      add_cmd(-32768, -32768, -32768);
      add_cmd(32767, -32768, 32767);
      add_cmd(16, 16, 0);        add_cmd(-1, -1, -1);
      add_cmd(1, 0, 0);          add_cmd(0, 0, 1);
      run_random(0, 1'b0);

      // gain of zero and a limit of one
      set_all(0, 0, 1, 0, 1);
      run_random(150, 1'b0);
      // all registers at their top, fixed mode
      set_all(65535, 65535, 32767, 1, 32767);
      run_random(190, 1'b1);
      // fixed mode with a zero divisor never scales
      set_all(longint'($urandom_range(0, 65535)), longint'($urandom_range(0, 8191)),
              12000, 1, 0);
      run_random(190, 1'b0);
      // a zero limit clamps everything to zero
      set_all(10240, 6144, 0, 0, 7000);
      run_random(150, 1'b0);
      // small fixed divisor below the real maximum
      set_all(longint'($urandom_range(0, 65535)), longint'($urandom_range(0, 65535)),
              longint'($urandom_range(1, 4000)), 1, longint'($urandom_range(1, 200)));
      run_random(190, 1'b0);
      // back near reset values; out-of-range index must be ignored
      set_all(10240, 6144, 8000, 0, 7000);
      write_reg(CSR_UNUSED, 16'h0001);
      write_reg(CSR_SPARE, 16'hffff);
      run_random(270, 1'b0);

      $display("covered %0d register settings, %0d responses, %0d with limiting applied",
               phases, responses, limited_seen);
      if (mismatches == 0 && expected_speeds.size() == 0)
         $display("mecanum_wheel_mixer_with_speed_limit regression: pass");
      else
         $display("mecanum_wheel_mixer_with_speed_limit regression: fail");
      $finish;
   end
endmodule
